[src/ssrl_pkg.sv]
// Shared types and codes for the sorted symbol range lookup block.
package ssrl_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic {
        SSRL_IDLE,
        SSRL_SEARCH
    } t_ssrl_state;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [31:0] name_handle;
        logic        name_is_empty;
    } t_ssrl_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_name;
        logic [31:0] offset;
    } t_ssrl_result;

    // One stored symbol entry.
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] name;
        logic        empty;
    } t_ssrl_entry;

    // Broadcast insert command seen by every cell.
    typedef struct packed {
        logic        en;
        t_ssrl_entry entry;
    } t_ssrl_ins;

    // Search token and the best match carried along the chain.
    typedef struct packed {
        logic        tok;
        logic        found;
        logic [31:0] name;
        logic [31:0] address;
    } t_ssrl_probe;

endpackage

[src/sorted_symbol_range_lookup.sv]
// Top level: symbol table as a chain of cells with insert and lookup control.
//
// The table is a row of TABLE_DEPTH cells kept in descending address order.
// An insert is taken while idle: every cell compares the new address at
// once and the tail of the row shifts by one cell unless the table is full;
// its result strobes on the next cycle and busy stays low, so inserts may
// follow each other every cycle while no lookup is in flight. A lookup sends
// a search token down the whole row, one cell per cycle, picking up the first
// entry with a non-empty name at or below the query address; its result
// strobes once the token has left the last cell, and busy is high until then.
// Results are shown for one cycle on o_strobe and cannot be stalled.
module sorted_symbol_range_lookup #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ssrl_pkg::t_ssrl_item   i_item,
    output logic                  o_strobe,
    output ssrl_pkg::t_ssrl_result o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    ssrl_pkg::t_ssrl_state  r_state;
    ssrl_pkg::t_ssrl_state  n_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_launch;
    logic [31:0]            r_query;
    logic                   r_strobe;
    logic                   n_strobe;
    ssrl_pkg::t_ssrl_result r_result;
    ssrl_pkg::t_ssrl_result n_result;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_done;
    ssrl_pkg::t_ssrl_ins    w_ins;
    logic                   w_keep  [TABLE_DEPTH+1];
    ssrl_pkg::t_ssrl_entry  w_entry [TABLE_DEPTH+1];
    ssrl_pkg::t_ssrl_probe  w_probe [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_tok_vec;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(TABLE_DEPTH));

    assign w_ins.en            = w_accept && (i_item.opcode == ssrl_pkg::OP_INSERT) && !w_full;
    assign w_ins.entry.address = i_item.address;
    assign w_ins.entry.name    = i_item.name_handle;
    assign w_ins.entry.empty   = i_item.name_is_empty;

    // head of the chain: always "kept" so cell 0 takes the new entry when it loses
    assign w_keep[0]          = 1'b1;
    assign w_entry[0]         = '0;
    assign w_probe[0].tok     = r_launch;
    assign w_probe[0].found   = 1'b0;
    assign w_probe[0].name    = '0;
    assign w_probe[0].address = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ssrl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (r_count > CW'(i)),
            .i_ins      (w_ins),
            .i_left_keep(w_keep[i]),
            .i_left     (w_entry[i]),
            .o_keep     (w_keep[i+1]),
            .o_entry    (w_entry[i+1]),
            .i_query    (r_query),
            .i_probe    (w_probe[i]),
            .o_probe    (w_probe[i+1])
        );
        assign w_tok_vec[i] = w_probe[i+1].tok;
    end

    assign w_done = w_probe[TABLE_DEPTH].tok;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssrl_pkg::SSRL_IDLE: begin
                if (w_accept && (i_item.opcode == ssrl_pkg::OP_LOOKUP)) begin
                    n_state = ssrl_pkg::SSRL_SEARCH;
                end
            end
            ssrl_pkg::SSRL_SEARCH: begin
                if (w_done) begin
                    n_state = ssrl_pkg::SSRL_IDLE;
                end
            end
            default: n_state = ssrl_pkg::SSRL_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ssrl_pkg::SSRL_IDLE:   busy = 1'b0;
            ssrl_pkg::SSRL_SEARCH: busy = 1'b1;
            default:               busy = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ins.en) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        n_strobe = 1'b0;
        n_result = r_result;
        if (w_accept && (i_item.opcode == ssrl_pkg::OP_INSERT)) begin
            n_strobe            = 1'b1;
            n_result.status     = w_full ? ssrl_pkg::ST_FULL : ssrl_pkg::ST_INSERTED;
            n_result.found_name = '0;
            n_result.offset     = '0;
        end else if (w_done) begin
            n_strobe = 1'b1;
            if (w_probe[TABLE_DEPTH].found) begin
                n_result.status     = ssrl_pkg::ST_FOUND;
                n_result.found_name = w_probe[TABLE_DEPTH].name;
                n_result.offset     = r_query - w_probe[TABLE_DEPTH].address;
            end else begin
                n_result.status     = ssrl_pkg::ST_NOT_FOUND;
                n_result.found_name = '0;
                n_result.offset     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssrl_pkg::SSRL_IDLE;
            r_count  <= '0;
            r_launch <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_launch <= w_accept && (i_item.opcode == ssrl_pkg::OP_LOOKUP);
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_item.opcode == ssrl_pkg::OP_LOOKUP)) begin
            r_query <= i_item.address;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one search token in the chain");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssrl_pkg::SSRL_IDLE) |-> (w_tok_vec == '0))
        else $error("search token in flight while idle");

    a_insert_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.opcode == ssrl_pkg::OP_INSERT)) |=> o_strobe)
        else $error("insert item without result");

endmodule

[src/ssrl_cell.sv]
// One table cell: holds an entry, shifts on insert, passes the search token on.
module ssrl_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ssrl_pkg::t_ssrl_ins   i_ins,
    input  logic                 i_left_keep,
    input  ssrl_pkg::t_ssrl_entry i_left,
    output logic                 o_keep,
    output ssrl_pkg::t_ssrl_entry o_entry,
    input  logic [31:0]          i_query,
    input  ssrl_pkg::t_ssrl_probe i_probe,
    output ssrl_pkg::t_ssrl_probe o_probe
);

    ssrl_pkg::t_ssrl_entry r_entry;
    ssrl_pkg::t_ssrl_entry n_entry;
    ssrl_pkg::t_ssrl_probe r_probe;
    ssrl_pkg::t_ssrl_probe n_probe;
    logic                  w_keep;
    logic                  w_match;

    assign w_keep  = i_valid && (r_entry.address >= i_ins.entry.address);
    assign w_match = i_valid && !r_entry.empty && (r_entry.address <= i_query);
    assign o_keep  = w_keep;
    assign o_entry = r_entry;
    assign o_probe = r_probe;

    always_comb begin
        n_entry = r_entry;
        if (i_ins.en && !w_keep) begin
            // first cell past the kept prefix takes the new entry, later ones shift
            if (i_left_keep) begin
                n_entry = i_ins.entry;
            end else begin
                n_entry = i_left;
            end
        end
    end

    always_comb begin
        n_probe = i_probe;
        if (i_probe.tok && !i_probe.found && w_match) begin
            n_probe.found   = 1'b1;
            n_probe.name    = r_entry.name;
            n_probe.address = r_entry.address;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

endmodule

[verif/tb.sv]
// Self-checking testbench for the sorted symbol range lookup block.
module tb;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          CLK_HALF     = 6;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          N_PER_PHASE  = 160;
    localparam int          REPORT_LIMIT = 10;

    typedef struct {
        ssrl_pkg::t_ssrl_item item;
        int unsigned          gap_pct;
    } t_pending_item;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    ssrl_pkg::t_ssrl_item   i_item;
    logic                   o_strobe;
    ssrl_pkg::t_ssrl_result o_result;

    t_pending_item          item_backlog[$];
    ssrl_pkg::t_ssrl_result pending_answers[$];
    logic [31:0]            loaded_addrs[$];

    // Shadow symbol table, kept in descending address order.
    ssrl_pkg::t_ssrl_entry  sym_table[TABLE_DEPTH];
    int unsigned            sym_count;

    logic          item_taken;
    int unsigned   cycle_count;
    int unsigned   mismatch_count;
    int unsigned   n_inserted, n_full, n_found, n_not_found;

    sorted_symbol_range_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one item to the shadow table and return the answer it should give.
    function automatic ssrl_pkg::t_ssrl_result symbol_table_answer(ssrl_pkg::t_ssrl_item it);
        ssrl_pkg::t_ssrl_result ans;
        int unsigned            pos;
        ans = '0;
        ans.status = ssrl_pkg::ST_NOT_FOUND;
        if (it.opcode == ssrl_pkg::OP_INSERT) begin
            if (sym_count >= TABLE_DEPTH) begin
                ans.status = ssrl_pkg::ST_FULL;
            end else begin
                pos = 0;
                // equal addresses stay ahead of the new entry
                while (pos < sym_count && sym_table[pos].address >= it.address)
                    pos++;
                for (int k = sym_count; k > pos; k--)
                    sym_table[k] = sym_table[k-1];
                sym_table[pos].address = it.address;
                sym_table[pos].name    = it.name_handle;
                sym_table[pos].empty   = it.name_is_empty;
                sym_count++;
                ans.status = ssrl_pkg::ST_INSERTED;
            end
        end else begin
            for (int i = 0; i < sym_count; i++) begin
                if (sym_table[i].address <= it.address && !sym_table[i].empty) begin
                    ans.status     = ssrl_pkg::ST_FOUND;
                    ans.found_name = sym_table[i].name;
                    ans.offset     = it.address - sym_table[i].address;
                    break;
                end
            end
        end
        return ans;
    endfunction

    task automatic queue_item(logic op, logic [31:0] addr, logic [31:0] name,
                              logic empty, int unsigned gap);
        t_pending_item p;
        p.item.opcode        = op;
        p.item.address       = addr;
        p.item.name_handle   = name;
        p.item.name_is_empty = empty;
        p.gap_pct            = gap;
        item_backlog.push_back(p);
        if (op == ssrl_pkg::OP_INSERT && loaded_addrs.size() < TABLE_DEPTH)
            loaded_addrs.push_back(addr);
    endtask

    task automatic queue_random_items(int n, int unsigned gap);
        logic [31:0] base, addr;
        int unsigned pick;
        for (int j = 0; j < n; j++) begin
            base = (loaded_addrs.size() != 0) ?
                   loaded_addrs[$urandom_range(loaded_addrs.size() - 1)] : $urandom;
            pick = $urandom_range(99);
            if ($urandom_range(99) < 60) begin
                if (pick < 25)      addr = base;
                else if (pick < 30) addr = 32'd0;
                else if (pick < 35) addr = 32'hFFFF_FFFF;
                else                addr = $urandom;
                queue_item(ssrl_pkg::OP_INSERT, addr, $urandom, $urandom_range(99) < 20, gap);
            end else begin
                if (pick < 40)      addr = base + $urandom_range(4095);
                else if (pick < 55) addr = base;
                else if (pick < 65) addr = base - 32'd1;
                else if (pick < 70) addr = 32'd0;
                else if (pick < 75) addr = 32'hFFFF_FFFF;
                else                addr = $urandom;
                // name fields are don't-care on a lookup
                queue_item(ssrl_pkg::OP_LOOKUP, addr, $urandom, $urandom_range(1), gap);
            end
        end
    endtask

    // Driver: hold an item until taken, then pick the next or idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            if (item_backlog.size() != 0 &&
                $urandom_range(99) >= item_backlog[0].gap_pct) begin
                start  <= 1'b1;
                i_item <= item_backlog[0].item;
                void'(item_backlog.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check the oldest expected answer, then predict the new item.
    always @(posedge i_clk) begin
        ssrl_pkg::t_ssrl_result exp_ans;
        cycle_count <= cycle_count + 1;
        item_taken  <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_answers.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("ERROR: stray result: status=%0d name=%h off=%h",
                                 o_result.status, o_result.found_name, o_result.offset);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_ans = pending_answers.pop_front();
                    if (o_result.status !== exp_ans.status ||
                        o_result.found_name !== exp_ans.found_name ||
                        o_result.offset !== exp_ans.offset) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"ERROR: expected status=%0d name=%h off=%h, ",
                                      "got status=%0d name=%h off=%h"},
                                     exp_ans.status, exp_ans.found_name, exp_ans.offset,
                                     o_result.status, o_result.found_name, o_result.offset);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                exp_ans = symbol_table_answer(i_item);
                pending_answers.push_back(exp_ans);
                case (exp_ans.status)
                    ssrl_pkg::ST_INSERTED:  n_inserted++;
                    ssrl_pkg::ST_FULL:      n_full++;
                    ssrl_pkg::ST_FOUND:     n_found++;
                    ssrl_pkg::ST_NOT_FOUND: n_not_found++;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d items not sent, %0d results missing",
                     cycle_count, item_backlog.size(), pending_answers.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        item_taken     = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        sym_count      = 0;
        n_inserted     = 0;
        n_full         = 0;
        n_found        = 0;
        n_not_found    = 0;

        // Empty table, equal addresses, empty names, field extremes.
        queue_item(ssrl_pkg::OP_LOOKUP, 32'd0,         32'hFFFF_FFFF, 1'b1, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'h0000_1000, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'h0000_1000, 32'h0000_0055, 1'b1, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h0000_0FFF, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h0000_1000, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'd0,         32'h1234_5678, 1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'h0000_2000, 32'h0000_DEAD, 1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h0000_2000, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h0000_1FFF, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h0000_0FFF, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'd0,         32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'h0000_3000, 32'h0BAD_0BAD, 1'b1, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h0000_3000, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'd0,         1'b0, 17);
        queue_item(ssrl_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'd0,         1'b0, 17);

        // Random traffic: enough inserts to run the table into full.
        queue_random_items(N_PER_PHASE, 17);
        queue_random_items(N_PER_PHASE, 48);
        queue_random_items(N_PER_PHASE, 0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_backlog.size() != 0 || start || pending_answers.size() != 0)
            @(posedge i_clk);
        // catch any stray result from a lookup still in flight
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        $display("Sent %0d inserts (%0d stored, %0d refused with the table full)",
                 n_inserted + n_full, n_inserted, n_full);
        $display("and %0d lookups (%0d hits, %0d misses) in %0d cycles",
                 n_found + n_not_found, n_found, n_not_found, cycle_count);
        if (pending_answers.size() != 0)
            $display("ERROR: %0d results never arrived", pending_answers.size());
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
